FILE: rtl/paged_memory_map_decoder_defines.svh
// Assertion helpers for the paged memory map decoder.
`ifndef PAGED_MEMORY_MAP_DECODER_DEFINES_SVH
`define PAGED_MEMORY_MAP_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PMMD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmmd assertion failed");
// Next-cycle implication, checked outside reset.
`define PMMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmmd assertion failed");
`else
`define PMMD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PMMD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/pmmd_pkg.sv
package pmmd_pkg;

  // Field widths
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int TARGET_W  = 3;
  localparam int BLOCK_W   = 6;
  localparam int ROMNUM_W  = 3;
  localparam int SUBPAGE_W = 8;
  localparam int OFFSET_W  = 14;
  localparam int RAMCNT_W  = 7;
  localparam int ROMEN_W   = 8;
  localparam int MASKS_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  localparam logic [RAMCNT_W-1:0] MAX_RAM_BLOCKS = 7'd64;

  // Operations
  localparam logic [OP_W-1:0] OP_READ       = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT_SET = 2'd2;

  // Targets
  localparam logic [TARGET_W-1:0] T_RAM    = 3'd0;
  localparam logic [TARGET_W-1:0] T_MON    = 3'd1;
  localparam logic [TARGET_W-1:0] T_PROM   = 3'd2;
  localparam logic [TARGET_W-1:0] T_NONE   = 3'd3;
  localparam logic [TARGET_W-1:0] T_SUBSET = 3'd4;
  localparam logic [TARGET_W-1:0] T_SELSET = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BLOCKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBPAGE_MASKS = 2'd2;

  // Reset values
  localparam logic [RAMCNT_W-1:0] RAM_BLOCKS_RST    = 7'd4;
  localparam logic [ROMEN_W-1:0]  ROM_ENABLE_RST    = 8'hFF;
  localparam logic [MASKS_W-1:0]  SUBPAGE_MASKS_RST = 64'h00000000000F0000;

  typedef struct packed {
    logic [TARGET_W-1:0]  target;
    logic [BLOCK_W-1:0]   ram_block;
    logic [ROMNUM_W-1:0]  rom_number;
    logic [SUBPAGE_W-1:0] rom_subpage;
    logic [OFFSET_W-1:0]  offset;
    logic                 write_strobe;
    logic [DATA_W-1:0]    write_data;
  } result_t;

endpackage

FILE: rtl/paged_memory_map_decoder.sv
// Paged memory map decoder: maps each 16-bit processor access to RAM block
// (16KB), monitor ROM, paged ROM (8KB, with subpage) or unmapped, and handles
// page-select and ROM-subpage writes. Two register stages: an input register
// and a result register, with the whole decode between them. One transaction
// is accepted per cycle when the output side keeps up. An accepted transaction
// passes through the input register and then the result register before its
// result is offered on the output. A stalled result holds the input register,
// and the input side stalls once both stages are full.
// s_tready stays low during reset.
// The page-select and subpage registers update as the item passes the decode
// stage, so the very next transaction already sees the new mapping.
// Configuration writes (ram_blocks, rom_on_mask, subpage_masks) are taken at
// any clock edge with cfg_wr_en high and must only be issued while the block is
// idle. Operation code 3 behaves as a read.
`include "paged_memory_map_decoder_defines.svh"

module paged_memory_map_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pmmd_pkg::S_TDATA_W-1:0]    s_tdata,   // address[15:0], data[23:16]
  input  logic [pmmd_pkg::OP_W-1:0]         s_tuser,   // operation[1:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pmmd_pkg::M_TDATA_W-1:0]    m_tdata,   // ram_block[5:0], rom_number[8:6],
                                                       // rom_subpage[16:9], offset[30:17],
                                                       // write_strobe[31], write_data[39:32]
  output logic [pmmd_pkg::TARGET_W-1:0]     m_tuser,   // target[2:0]
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [pmmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmmd_pkg::MASKS_W-1:0]      cfg_data
);
  import pmmd_pkg::*;

  // Configuration registers
  logic [RAMCNT_W-1:0] ram_blocks;
  logic [ROMEN_W-1:0]  rom_on_mask;
  logic [MASKS_W-1:0]  subpage_masks;

  // Mapping state
  logic [DATA_W-1:0]   page_select, page_select_next;
  logic [DATA_W-1:0]   rom_subpage_reg, rom_subpage_reg_next;

  // Input register
  logic                in_valid;
  logic [OP_W-1:0]     in_op;
  logic [ADDR_W-1:0]   in_addr;
  logic [DATA_W-1:0]   in_data;

  // Result register
  result_t             res, res_next;

  logic out_free;
  logic advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !rst && (!in_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_blocks    <= RAM_BLOCKS_RST;
      rom_on_mask   <= ROM_ENABLE_RST;
      subpage_masks <= SUBPAGE_MASKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RAM_BLOCKS:    ram_blocks    <= cfg_data[RAMCNT_W-1:0];
        CFG_ROM_ENABLE:    rom_on_mask   <= cfg_data[ROMEN_W-1:0];
        CFG_SUBPAGE_MASKS: subpage_masks <= cfg_data;
        default: ;  // no register there
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_addr <= s_tdata[ADDR_W-1:0];
      in_data <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  // Decode
  logic [2:0]          win;
  logic [1:0]          page;
  logic [3:0]          p;
  logic                wr;
  logic [RAMCNT_W-1:0] blk;
  logic [ROMNUM_W-1:0] rom;
  logic [SUBPAGE_W-1:0] mask;

  assign win  = in_addr[15:13];
  assign page = in_addr[15:14];
  assign p    = page_select[3:0];
  assign wr   = (in_op == OP_WRITE);
  assign rom  = page_select[6:4];
  assign mask = subpage_masks[8*rom +: 8];

  // Candidate RAM block for the two paging modes
  always_comb begin
    if (page_select[7]) begin
      if (p != 4'd0) begin
        blk = (RAMCNT_W'(p) << 1) + RAMCNT_W'(p) + 7'd1 + RAMCNT_W'(page);
      end else begin
        blk = 7'd3 - RAMCNT_W'(page);
      end
    end else begin
      blk = (RAMCNT_W'(p) << 1) + 7'd1 + (7'd2 - RAMCNT_W'(page));
    end
  end

  always_comb begin
    res_next              = '0;
    res_next.target       = T_NONE;
    res_next.write_data   = in_data;
    page_select_next      = page_select;
    rom_subpage_reg_next  = rom_subpage_reg;
    priority if (in_op == OP_SELECT_SET) begin
      page_select_next = in_data;
      res_next.target  = T_SELSET;
    end else if (page == 2'd3) begin
      // top 16KB: always block 0
      res_next.target       = T_RAM;
      res_next.offset       = in_addr[OFFSET_W-1:0];
      res_next.write_strobe = wr;
    end else if (!page_select[7] && win == 3'd0) begin
      if (wr) begin
        rom_subpage_reg_next = in_data;
        res_next.target      = T_SUBSET;
      end else begin
        res_next.target = T_MON;
        res_next.offset = {1'b0, in_addr[12:0]};
      end
    end else if (!page_select[7] && win == 3'd1) begin
      if (rom_on_mask[rom]) begin
        res_next.target      = T_PROM;
        res_next.rom_number  = rom;
        res_next.rom_subpage = rom_subpage_reg & mask;
        res_next.offset      = {1'b0, in_addr[12:0]};
      end
    end else if (!page_select[7] && page == 2'd1 && p == 4'hF) begin
      res_next.target = T_NONE;
    end else if (blk < ram_blocks && blk < MAX_RAM_BLOCKS) begin
      res_next.target       = T_RAM;
      res_next.ram_block    = blk[BLOCK_W-1:0];
      res_next.offset       = in_addr[OFFSET_W-1:0];
      res_next.write_strobe = wr;
    end else begin
      res_next.target = T_NONE;  // block not fitted
    end
  end

  // State and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      page_select     <= '0;
      rom_subpage_reg <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (advance) begin
        page_select     <= page_select_next;
        rom_subpage_reg <= rom_subpage_reg_next;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tuser = res.target;
  assign m_tdata = {res.write_data, res.write_strobe, res.offset,
                    res.rom_subpage, res.rom_number, res.ram_block};

  // Checks
  `PMMD_ASSERT_IMPL(a_strobe_only_ram, clk, rst, m_tvalid && res.write_strobe, res.target == T_RAM)
  `PMMD_ASSERT_IMPL(a_block_only_ram, clk, rst, m_tvalid && res.ram_block != '0, res.target == T_RAM)
  `PMMD_ASSERT_IMPL(a_none_clean, clk, rst, m_tvalid && res.target == T_NONE, res.offset == '0 && res.rom_number == '0)
  `PMMD_ASSERT_NEXT(a_select_load, clk, rst, advance && in_op == OP_SELECT_SET, page_select == $past(in_data))
  `PMMD_ASSERT_NEXT(a_subpage_load, clk, rst, advance && res_next.target == T_SUBSET, rom_subpage_reg == $past(in_data))

endmodule

FILE: bench/paged_memory_map_decoder_tb.sv
`timescale 1ns / 1ps

module paged_memory_map_decoder_tb;
  import pmmd_pkg::*;

  // Operation code 3 has no name in the package; the block treats it as a read.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int LONG_HOLD = 120;   // receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 6;    // two-stage pipe, plus margin

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } access_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports; the inputs are known from time zero
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // address[15:0], data[23:16]
  logic [OP_W-1:0]      s_tuser = '0;   // operation[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // ram_block[5:0], rom_number[8:6],
                                        // rom_subpage[16:9], offset[30:17],
                                        // write_strobe[31], write_data[39:32]
  logic [TARGET_W-1:0]  m_tuser;        // target[2:0]
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASKS_W-1:0]   cfg_data = '0;

  paged_memory_map_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Mapper model: its own copy of the config registers and of the two state
  // bytes. Updated when an access is accepted, same as the decode stage.
  // ---------------------------------------------------------------------------
  logic [RAMCNT_W-1:0]  fitted_blocks = RAM_BLOCKS_RST;
  logic [ROMEN_W-1:0]   rom_en_mask   = ROM_ENABLE_RST;
  logic [MASKS_W-1:0]   subpage_masks = SUBPAGE_MASKS_RST;
  logic [7:0]           page_sel      = 8'h00;
  logic [7:0]           subpage_latch = 8'h00;

  // RAM access to a computed block; unfitted blocks read as unmapped.
  function automatic result_t ram_access(input int blk, input access_t a);
    result_t r;
    r = '0;
    r.write_data = a.data;
    if (blk >= int'(fitted_blocks) || blk >= int'(MAX_RAM_BLOCKS)) begin
      r.target = T_NONE;
    end else begin
      r.target       = T_RAM;
      r.ram_block    = blk[BLOCK_W-1:0];
      r.offset       = a.addr[13:0];
      r.write_strobe = (a.op == OP_WRITE);
    end
    return r;
  endfunction

  function automatic result_t decode_access(input access_t a);
    result_t r;
    logic [2:0] win;
    logic [1:0] page;
    logic [3:0] p;
    logic [2:0] rom;
    r    = '0;
    win  = a.addr[15:13];
    page = win[2:1];
    p    = page_sel[3:0];
    rom  = page_sel[6:4];
    r.write_data = a.data;
    if (a.op == OP_SELECT_SET) begin
      page_sel = a.data;
      r.target = T_SELSET;
    end else if (page == 2'd3) begin
      // top 16KB: always block 0, no fitted check
      r.target       = T_RAM;
      r.offset       = a.addr[13:0];
      r.write_strobe = (a.op == OP_WRITE);
    end else if (page_sel[7]) begin
      // all-RAM map; P = 0 runs backwards
      if (p != 4'd0)
        r = ram_access(3 * int'(p) + 1 + int'(page), a);
      else
        r = ram_access(3 - int'(page), a);
    end else if (win == 3'd0) begin
      if (a.op == OP_WRITE) begin
        subpage_latch = a.data;
        r.target = T_SUBSET;
      end else begin
        r.target = T_MON;
        r.offset = {1'b0, a.addr[12:0]};
      end
    end else if (win == 3'd1) begin
      if (!rom_en_mask[rom]) begin
        r.target = T_NONE;
      end else begin
        r.target      = T_PROM;
        r.rom_number  = rom;
        r.rom_subpage = subpage_latch & subpage_masks[8*rom +: 8];
        r.offset      = {1'b0, a.addr[12:0]};
      end
    end else if (page == 2'd1 && p == 4'hF) begin
      r.target = T_NONE;
    end else begin
      r = ram_access(2 * int'(p) + 1 + (2 - int'(page)), a);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  access_t pending_q[$];     // accesses waiting for the driver
  result_t expected_q[$];    // predicted results, oldest first
  access_t cur_access;
  int      queued_count = 0;
  int      sent_count = 0;
  int      mismatches = 0;
  bit      gaps_on = 1'b1;   // random idling on both sides
  int      holds_wanted = 0; // long receiver hold-offs requested / started
  int      holds_done = 0;
  int      send_gap = 0;
  int      hold_left = 0;
  result_t seen;
  result_t wanted;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued accesses; predicts each one as it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(decode_access(cur_access));
        sent_count++;
        if (gaps_on && $urandom_range(0, 3) == 0)
          send_gap = pick_gap();
      end
      // hold the current transaction while it is stalled
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_access = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_access.data, cur_access.addr};
          s_tuser  <= cur_access.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random back-pressure, plus long hold-offs on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_done != holds_wanted) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (!gaps_on || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      hold_left = pick_gap() - 1;
      m_tready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.target       = m_tuser;
      seen.ram_block    = m_tdata[5:0];
      seen.rom_number   = m_tdata[8:6];
      seen.rom_subpage  = m_tdata[16:9];
      seen.offset       = m_tdata[30:17];
      seen.write_strobe = m_tdata[31];
      seen.write_data   = m_tdata[39:32];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected, target %0d", $realtime, seen.target);
      end else begin
        wanted = expected_q.pop_front();
        if (seen.target !== wanted.target || seen.ram_block !== wanted.ram_block ||
            seen.rom_number !== wanted.rom_number ||
            seen.rom_subpage !== wanted.rom_subpage ||
            seen.offset !== wanted.offset || seen.write_strobe !== wanted.write_strobe ||
            seen.write_data !== wanted.write_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch (exp/got) target %0d/%0d block %0d/%0d rom %0d/%0d",
                      " sub %h/%h ofs %h/%h we %b/%b wd %h/%h"}, $realtime,
                     wanted.target, seen.target, wanted.ram_block, seen.ram_block,
                     wanted.rom_number, seen.rom_number, wanted.rom_subpage,
                     seen.rom_subpage, wanted.offset, seen.offset,
                     wanted.write_strobe, seen.write_strobe,
                     wanted.write_data, seen.write_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [DATA_W-1:0] data);
    access_t a;
    a.op   = op;
    a.addr = addr;
    a.data = data;
    pending_q.push_back(a);
    queued_count++;
  endtask

  // Wait until every queued transaction went in and every result came out.
  task automatic drain();
    while (sent_count != queued_count || expected_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASKS_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_RAM_BLOCKS:    fitted_blocks = val[RAMCNT_W-1:0];
      CFG_ROM_ENABLE:    rom_en_mask = val[ROMEN_W-1:0];
      CFG_SUBPAGE_MASKS: subpage_masks = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int blocks, input logic [7:0] en, input logic [63:0] masks);
    write_reg(CFG_RAM_BLOCKS, MASKS_W'(blocks));
    write_reg(CFG_ROM_ENABLE, MASKS_W'(en));
    write_reg(CFG_SUBPAGE_MASKS, masks);
  endtask

  // Random accesses. Select writes favor small P so RAM hits stay common;
  // a few are fully random.
  task automatic random_batch(input int n);
    int k;
    logic [7:0] sel;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 12) begin
        if ($urandom_range(0, 3) == 0)
          sel = 8'($urandom_range(0, 255));
        else
          sel = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 2))};
        offer(OP_SELECT_SET, 16'($urandom_range(0, 65535)), sel);
      end else if (k < 16) begin
        offer(OP_RESERVED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else begin
        offer(k < 58 ? OP_READ : OP_WRITE, 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at reset config (4 blocks, all ROMs on, ROM 2 has 16 subpages).
    offer(OP_READ,       16'h0000, 8'h00);  // monitor ROM
    offer(OP_READ,       16'h1FFF, 8'hFF);
    offer(OP_WRITE,      16'h0005, 8'hA5);  // subpage set
    offer(OP_SELECT_SET, 16'h0000, 8'h20);  // ROM 2, P = 0
    offer(OP_READ,       16'h2000, 8'h00);  // paged ROM, masked subpage
    offer(OP_WRITE,      16'h3FFF, 8'h5A);  // ROM window write, no strobe
    offer(OP_READ,       16'h4000, 8'h00);  // block 2
    offer(OP_WRITE,      16'h7FFF, 8'hFF);
    offer(OP_READ,       16'h8000, 8'h00);  // block 1
    offer(OP_WRITE,      16'hBFFF, 8'h3C);
    offer(OP_WRITE,      16'hC000, 8'hFF);  // top block
    offer(OP_RESERVED,   16'hFFFF, 8'h81);  // code 3 acts as a read
    offer(OP_RESERVED,   16'h0005, 8'h11);  // ... and never sets the subpage
    offer(OP_SELECT_SET, 16'hFFFF, 8'h0F);  // P = 15, bit 7 clear
    offer(OP_READ,       16'h4000, 8'h00);  // hole at 0x4000
    offer(OP_WRITE,      16'h8000, 8'h77);  // block 31, not fitted
    offer(OP_SELECT_SET, 16'h0000, 8'h8F);  // all-RAM, P = 15
    offer(OP_WRITE,      16'h0000, 8'h99);  // block 46, not fitted
    offer(OP_SELECT_SET, 16'h0000, 8'h80);  // all-RAM, reversed order
    offer(OP_READ,       16'h0000, 8'h00);  // block 3
    offer(OP_WRITE,      16'h4001, 8'h42);  // block 2
    offer(OP_READ,       16'hA000, 8'h00);  // block 1
    offer(OP_SELECT_SET, 16'h0000, 8'h70);  // ROM 7, bit 7 clear
    offer(OP_READ,       16'h2ABC, 8'h00);
    drain();

    // extremes: everything fitted and open
    configure(64, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    random_batch(50);

    // extremes: minimum RAM, all ROMs off, zero masks
    configure(2, 8'h00, 64'h0);
    random_batch(50);

    // Long hold-off at the output while the sender streams without gaps.
    configure(64, 8'hFF, 64'h0F0F_0707_0303_0101);
    gaps_on = 1'b0;
    holds_wanted++;
    random_batch(40);
    gaps_on = 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      configure($urandom_range(2, 64), 8'($urandom_range(0, 255)), {$urandom, $urandom});
      gaps_on = (ph != 2);
      random_batch(50);
    end

    if (mismatches == 0)
      $display("** paged_memory_map_decoder: PASSED **");
    else
      $display("** paged_memory_map_decoder: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("** paged_memory_map_decoder: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pmmd_pkg.sv
rtl/paged_memory_map_decoder.sv
bench/paged_memory_map_decoder_tb.sv
